// File: rtl/core/pae_pkg.sv
package pae_pkg;

   localparam int DEPTH     = 256;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int DATA_W    = 32;
   localparam int POS_W     = 9;
   localparam int COUNT_W   = 9;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_SET    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      op_type                    operation;
      logic signed [DATA_W-1:0]  value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic                      found;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

endpackage

// File: rtl/core/pae_ram.sv
module pae_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/positional_array_engine_unit.sv
// One request at a time; the next is accepted once the previous result is registered.
// Set, empty find, removal of the last entry and rejects go straight to the result;
// insert moves entries up from the end down to the position, then writes the value;
// remove moves entries down from the position; find compares every entry. Walks run at
// one entry moved or compared per cycle through the single RAM port pair.
// Reset clears the count and the control state; entry storage is not cleared.
module positional_array_engine_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pae_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pae_pkg::rsp_type rsp_data
);

   localparam int AW = pae_pkg::ADDR_W;
   localparam int CW = pae_pkg::CNT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_SCAN,
      S_DRAIN,
      S_FINAL,
      S_RESULT
   } state_type;

   state_type                   state_ff, state_in;
   pae_pkg::op_type             op_ff, op_in;
   logic [pae_pkg::DATA_W-1:0]  value_ff, value_in;
   logic [AW-1:0]               pos_ff, pos_in;
   logic [CW-1:0]               cursor_ff, cursor_in;
   logic [AW-1:0]               dst_ff, dst_in;
   logic                        rd_valid_ff, rd_valid_in;
   logic                        found_ff, found_in;
   pae_pkg::status_type         status_ff, status_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pae_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                        accept;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [pae_pkg::DATA_W-1:0]  wr_data;
   logic [AW-1:0]               rd_addr;
   logic [pae_pkg::DATA_W-1:0]  rd_data;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // read address per walk direction
   always_comb begin
      unique case (state_ff)
         S_SHIFT_UP:   rd_addr = AW'(cursor_ff - CW'(1));
         S_SHIFT_DOWN: rd_addr = AW'(cursor_ff + CW'(1));
         default:      rd_addr = AW'(cursor_ff);
      endcase
   end

   // write port: moved entry, new value at insert point, or direct set
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = dst_ff;
      wr_data = rd_data;
      if (rd_valid_ff && op_ff != pae_pkg::OP_FIND) begin
         wr_en = 1'b1;
      end else if (state_ff == S_FINAL) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff;
         wr_data = value_ff;
      end else if (accept && req_data.operation == pae_pkg::OP_SET &&
                   32'(req_data.position) < 32'(count_ff)) begin
         wr_en   = 1'b1;
         wr_addr = AW'(req_data.position);
         wr_data = req_data.value;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      pos_in       = pos_ff;
      cursor_in    = cursor_ff;
      dst_in       = dst_ff;
      rd_valid_in  = 1'b0;
      found_in     = found_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rd_valid_ff && op_ff == pae_pkg::OP_FIND && rd_data == value_ff) begin
         found_in = 1'b1;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_data.operation;
               value_in  = req_data.value;
               pos_in    = AW'(req_data.position);
               found_in  = 1'b0;
               status_in = pae_pkg::ST_OK;
               state_in  = S_RESULT;
               unique case (req_data.operation)
                  pae_pkg::OP_INSERT: begin
                     if (32'(req_data.position) > 32'(count_ff)) begin
                        status_in = pae_pkg::ST_RANGE;
                     end else if (count_ff == CW'(pae_pkg::DEPTH)) begin
                        status_in = pae_pkg::ST_FULL;
                     end else begin
                        count_in  = count_ff + CW'(1);
                        cursor_in = count_ff;
                        state_in  = (32'(req_data.position) == 32'(count_ff)) ?
                                    S_FINAL : S_SHIFT_UP;
                     end
                  end
                  pae_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = pae_pkg::ST_EMPTY;
                     end else if (32'(req_data.position) >= 32'(count_ff)) begin
                        status_in = pae_pkg::ST_RANGE;
                     end else begin
                        count_in  = count_ff - CW'(1);
                        cursor_in = CW'(req_data.position);
                        if (32'(req_data.position) + 32'd1 < 32'(count_ff)) begin
                           state_in = S_SHIFT_DOWN;
                        end
                     end
                  end
                  pae_pkg::OP_FIND: begin
                     cursor_in = '0;
                     if (count_ff != '0) begin
                        state_in = S_SCAN;
                     end
                  end
                  pae_pkg::OP_SET: begin
                     if (32'(req_data.position) >= 32'(count_ff)) begin
                        status_in = pae_pkg::ST_RANGE;
                     end
                  end
                  default: status_in = pae_pkg::ST_OK;
               endcase
            end
         end
         S_SHIFT_UP: begin
            rd_valid_in = 1'b1;
            dst_in      = AW'(cursor_ff);
            cursor_in   = cursor_ff - CW'(1);
            if (cursor_ff == CW'(pos_ff) + CW'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_SHIFT_DOWN: begin
            // count already holds the new value: last source is count
            rd_valid_in = 1'b1;
            dst_in      = AW'(cursor_ff);
            cursor_in   = cursor_ff + CW'(1);
            if (cursor_ff + CW'(1) == count_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_SCAN: begin
            rd_valid_in = 1'b1;
            cursor_in   = cursor_ff + CW'(1);
            if (cursor_ff + CW'(1) == count_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = (op_ff == pae_pkg::OP_INSERT) ? S_FINAL : S_RESULT;
         end
         S_FINAL: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = status_ff;
               rsp_data_in.found  = found_ff;
               rsp_data_in.count  = pae_pkg::COUNT_W'(count_ff);
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_valid_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      value_ff    <= value_in;
      pos_ff      <= pos_in;
      cursor_ff   <= cursor_in;
      dst_ff      <= dst_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   pae_ram #(
      .WIDTH (pae_pkg::DATA_W),
      .DEPTH (pae_pkg::DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= pae_pkg::DEPTH)
      else $error("entry count above capacity");

   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !rd_valid_ff)
      else $error("read data pending while accepting a request");

   a_reject_keeps_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESULT && status_ff != pae_pkg::ST_OK |-> $stable(count_ff))
      else $error("rejected request changed the count");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT_DOWN || state_ff == S_SCAN |-> cursor_ff < count_ff)
      else $error("walk cursor past the last entry");
`endif

endmodule
